[hw/rtl/gpkd_pkg.sv]
// ---------------------------------------------------------------------------
// gpkd_pkg
// shared types and constants for the gamepad poll and key decode block
// ---------------------------------------------------------------------------
package gpkd_pkg;

   // configuration register widths, indexes and reset values
   localparam int CFG_W           = 10;
   localparam int CSR_INDEX_W     = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_PERIOD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BYTE_GAP    = 2'd1;
   localparam logic [CFG_W-1:0] HALF_PERIOD_RESET = 10'd10;
   localparam logic [CFG_W-1:0] BYTE_GAP_RESET    = 10'd16;

   // poll length and reply layout
   localparam int BYTES_PER_POLL_DEFAULT = 9;
   localparam int REPLY_BYTES            = 8;
   localparam int BUTTON_COUNT           = 16;
   localparam int KEY_W                  = 5;

   // command bytes shifted out at the head of a poll
   localparam logic [7:0] CMD_POLL_START = 8'h01;
   localparam logic [7:0] CMD_READ_DATA  = 8'h42;

   // pin levels after one tick
   typedef struct packed {
      logic select_n;
      logic clock_level;
      logic command_bit;
   } gpkd_pins_type;

   // end-of-poll event with the captured reply bytes 1..8
   typedef struct packed {
      logic                        done;
      logic [REPLY_BYTES-1:0][7:0] bytes;
   } gpkd_finish_type;

   // decoded and held poll results
   typedef struct packed {
      logic [KEY_W-1:0]        key_code;
      logic [7:0]              id_byte;
      logic [BUTTON_COUNT-1:0] buttons;
      logic [7:0]              right_x;
      logic [7:0]              right_y;
      logic [7:0]              left_x;
      logic [7:0]              left_y;
   } gpkd_held_type;

   // one result transaction
   typedef struct packed {
      gpkd_pins_type pins;
      logic          done_res;
      gpkd_held_type held;
   } gpkd_result_type;

endpackage

[hw/rtl/gpkd_seq.sv]
// ---------------------------------------------------------------------------
// gpkd_seq
// poll sequencer: half-period timer, bit and byte counters, reply capture
// ---------------------------------------------------------------------------
module gpkd_seq #(
   parameter int BYTES_PER_POLL = gpkd_pkg::BYTES_PER_POLL_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          tick,
   input  logic                          cmd,
   input  logic                          data_in,
   input  logic [gpkd_pkg::CFG_W-1:0]    half_period,
   input  logic [gpkd_pkg::CFG_W-1:0]    byte_gap,
   output gpkd_pkg::gpkd_pins_type       pins,
   output gpkd_pkg::gpkd_finish_type     finish
);
   import gpkd_pkg::*;

   localparam int BYTE_IDX_W = $clog2(BYTES_PER_POLL + 1);
   localparam int CMP_W      = BYTE_IDX_W + 4;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_HIGH,
      PH_LOW,
      PH_GAP
   } phase_type;

   phase_type                    phase_ff, phase_in;
   logic                         busy_ff, busy_in;
   logic [CFG_W-1:0]             timer_ff, timer_in;
   logic [2:0]                   bit_ff, bit_in;
   logic [BYTE_IDX_W-1:0]        byte_ff, byte_in;
   logic [REPLY_BYTES-1:0][7:0]  capture_ff, capture_in;
   logic                         done_in;
   logic [CFG_W:0]               timer_inc;
   logic [CMP_W-1:0]             byte_wide;
   logic [BYTE_IDX_W-1:0]        byte_inc;
   logic [2:0]                   slot;
   logic [7:0]                   cmd_val;

   assign timer_inc = {1'b0, timer_ff} + (CFG_W+1)'(1);
   assign byte_wide = CMP_W'(byte_ff);
   assign byte_inc  = byte_ff + BYTE_IDX_W'(1);
   assign slot      = 3'(byte_ff - BYTE_IDX_W'(1));

   // next state for one tick
   always_comb begin
      phase_in   = phase_ff;
      busy_in    = busy_ff;
      timer_in   = timer_ff;
      bit_in     = bit_ff;
      byte_in    = byte_ff;
      capture_in = capture_ff;
      done_in    = 1'b0;
      if (!busy_ff) begin
         if (cmd) begin
            busy_in    = 1'b1;
            phase_in   = PH_HIGH;
            timer_in   = '0;
            bit_in     = '0;
            byte_in    = '0;
            capture_in = '0;
         end
      end else begin
         unique case (phase_ff)
            PH_HIGH: begin
               if (timer_inc >= {1'b0, half_period}) begin
                  phase_in = PH_LOW;
                  timer_in = '0;
               end else begin
                  timer_in = timer_inc[CFG_W-1:0];
               end
            end
            PH_LOW: begin
               if (timer_inc >= {1'b0, half_period}) begin
                  // rising clock edge: sample the reply bit
                  if (data_in && byte_wide >= CMP_W'(1) && byte_wide <= CMP_W'(REPLY_BYTES))
                     capture_in[slot][bit_ff] = 1'b1;
                  timer_in = '0;
                  if (bit_ff != 3'd7) begin
                     bit_in   = bit_ff + 3'd1;
                     phase_in = PH_HIGH;
                  end else if (byte_gap != '0) begin
                     phase_in = PH_GAP;
                  end else begin
                     bit_in  = '0;
                     byte_in = byte_inc;
                     if (byte_inc >= BYTE_IDX_W'(BYTES_PER_POLL)) begin
                        busy_in  = 1'b0;
                        phase_in = PH_IDLE;
                        done_in  = 1'b1;
                     end else begin
                        phase_in = PH_HIGH;
                     end
                  end
               end else begin
                  timer_in = timer_inc[CFG_W-1:0];
               end
            end
            PH_GAP: begin
               if (timer_inc >= {1'b0, byte_gap}) begin
                  timer_in = '0;
                  bit_in   = '0;
                  byte_in  = byte_inc;
                  if (byte_inc >= BYTE_IDX_W'(BYTES_PER_POLL)) begin
                     busy_in  = 1'b0;
                     phase_in = PH_IDLE;
                     done_in  = 1'b1;
                  end else begin
                     phase_in = PH_HIGH;
                  end
               end else begin
                  timer_in = timer_inc[CFG_W-1:0];
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // command byte for the byte being shifted
   always_comb begin
      if (byte_in == BYTE_IDX_W'(0))
         cmd_val = CMD_POLL_START;
      else if (byte_in == BYTE_IDX_W'(1))
         cmd_val = CMD_READ_DATA;
      else
         cmd_val = 8'h00;
   end

   // pin levels as they stand after this tick
   always_comb begin
      pins.select_n    = ~busy_in;
      pins.clock_level = ~(busy_in && phase_in == PH_LOW);
      pins.command_bit = busy_in && (phase_in == PH_HIGH || phase_in == PH_LOW)
                         && cmd_val[bit_in];
      finish.done      = tick && done_in;
      finish.bytes     = capture_in;
   end

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         busy_ff    <= 1'b0;
         timer_ff   <= '0;
         bit_ff     <= '0;
         byte_ff    <= '0;
         capture_ff <= '0;
      end else if (tick) begin
         phase_ff   <= phase_in;
         busy_ff    <= busy_in;
         timer_ff   <= timer_in;
         bit_ff     <= bit_in;
         byte_ff    <= byte_in;
         capture_ff <= capture_in;
      end
   end

endmodule

[hw/rtl/gpkd_key.sv]
// ---------------------------------------------------------------------------
// gpkd_key
// held reply bytes and key code decode with the one-shot select latch
// ---------------------------------------------------------------------------
module gpkd_key (
   input  logic                      clock,
   input  logic                      reset,
   input  gpkd_pkg::gpkd_finish_type finish,
   output gpkd_pkg::gpkd_held_type   held
);
   import gpkd_pkg::*;

   gpkd_held_type           held_ff, held_in;
   logic                    latch_ff, latch_in;
   logic [BUTTON_COUNT-1:0] hk;
   logic [3:0]              found;
   logic                    none_pressed;

   assign hk = {finish.bytes[3], finish.bytes[2]};

   // lowest pressed button (bits read 0 when pressed)
   always_comb begin
      found        = '0;
      none_pressed = 1'b1;
      for (int i = BUTTON_COUNT - 1; i >= 0; i--) begin
         if (!hk[i]) begin
            found        = 4'(i);
            none_pressed = 1'b0;
         end
      end
   end

   // results and key code on poll completion
   always_comb begin
      held_in  = held_ff;
      latch_in = latch_ff;
      if (finish.done) begin
         held_in.id_byte = finish.bytes[0];
         held_in.buttons = hk;
         held_in.right_x = finish.bytes[4];
         held_in.right_y = finish.bytes[5];
         held_in.left_x  = finish.bytes[6];
         held_in.left_y  = finish.bytes[7];
         if (hk == '0) begin
            // every button down reads as no key
            held_in.key_code = '0;
         end else if (none_pressed) begin
            latch_in         = 1'b0;
            held_in.key_code = '0;
         end else if (found == 4'd0) begin
            // select reports once per press
            if (!latch_ff) begin
               latch_in         = 1'b1;
               held_in.key_code = KEY_W'(1);
            end else begin
               held_in.key_code = '0;
            end
         end else begin
            held_in.key_code = KEY_W'(found) + KEY_W'(1);
         end
      end
   end

   assign held = held_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= '0;
         latch_ff <= 1'b0;
      end else begin
         held_ff  <= held_in;
         latch_ff <= latch_in;
      end
   end

endmodule

[hw/rtl/gpkd_out.sv]
// ---------------------------------------------------------------------------
// gpkd_out
// result register with a skid stage so input and output stall independently
// ---------------------------------------------------------------------------
module gpkd_out (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  gpkd_pkg::gpkd_result_type push_data,
   output logic                      can_push,
   output logic                      out_valid,
   input  logic                      out_ready,
   output gpkd_pkg::gpkd_result_type out_data
);
   import gpkd_pkg::*;

   logic            main_valid_ff, skid_valid_ff;
   gpkd_result_type main_data_ff, skid_data_ff;
   logic            take;

   assign take      = main_valid_ff && out_ready;
   assign can_push  = ~skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (push) begin
         if (!main_valid_ff || take)
            main_valid_ff <= 1'b1;
         else
            skid_valid_ff <= 1'b1;
      end else if (take) begin
         main_valid_ff <= skid_valid_ff;
         skid_valid_ff <= 1'b0;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (push) begin
         if (!main_valid_ff || take)
            main_data_ff <= push_data;
         else
            skid_data_ff <= push_data;
      end else if (take && skid_valid_ff) begin
         main_data_ff <= skid_data_ff;
      end
   end

endmodule

[hw/rtl/gamepad_poll_and_key_decode.sv]
// ---------------------------------------------------------------------------
// gamepad_poll_and_key_decode
// bit-banged gamepad poll stepped by timer ticks, with button key decode
// ---------------------------------------------------------------------------
//  channel | ports                          | handshake
//  --------+--------------------------------+---------------------------------
//  req     | req_cmd, req_data_in           | req_valid / req_ready
//  rsp     | pin levels, done, key, replies | rsp_valid / rsp_ready
//  csr     | csr_index, csr_wdata           | csr_write_en, no wait
//
//  one tick is taken per clock cycle while req_ready is high; its result is
//  registered. a result register plus a skid stage let a new tick in while
//  an earlier result waits, so req_ready drops only when both hold a result.
//  synchronous reset clears the sequencer, latch and held results.
// ---------------------------------------------------------------------------
module gamepad_poll_and_key_decode #(
   parameter int BYTES_PER_POLL = gpkd_pkg::BYTES_PER_POLL_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_cmd,
   input  logic                                req_data_in,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_select_n,
   output logic                                rsp_clock_level,
   output logic                                rsp_command_bit,
   output logic                                rsp_done_res,
   output logic [gpkd_pkg::KEY_W-1:0]          rsp_key_code,
   output logic [7:0]                          rsp_id_byte,
   output logic [gpkd_pkg::BUTTON_COUNT-1:0]   rsp_buttons,
   output logic [7:0]                          rsp_right_x,
   output logic [7:0]                          rsp_right_y,
   output logic [7:0]                          rsp_left_x,
   output logic [7:0]                          rsp_left_y,
   input  logic                                csr_write_en,
   input  logic [gpkd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [gpkd_pkg::CFG_W-1:0]          csr_wdata
);
   import gpkd_pkg::*;

   logic            [CFG_W-1:0] half_period_ff;
   logic            [CFG_W-1:0] byte_gap_ff;
   logic                        accept;
   gpkd_pins_type               pins;
   gpkd_finish_type             finish;
   gpkd_held_type               held;
   gpkd_result_type             result;
   gpkd_result_type             rsp_data;

   assign accept = req_valid && req_ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= HALF_PERIOD_RESET;
         byte_gap_ff    <= BYTE_GAP_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_HALF_PERIOD: half_period_ff <= csr_wdata;
            CSR_BYTE_GAP:    byte_gap_ff    <= csr_wdata;
            default:         ;
         endcase
      end
   end

   gpkd_seq #(
      .BYTES_PER_POLL (BYTES_PER_POLL)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .tick        (accept),
      .cmd         (req_cmd),
      .data_in     (req_data_in),
      .half_period (half_period_ff),
      .byte_gap    (byte_gap_ff),
      .pins        (pins),
      .finish      (finish)
   );

   gpkd_key u_key (
      .clock  (clock),
      .reset  (reset),
      .finish (finish),
      .held   (held)
   );

   // assemble the result transaction
   always_comb begin
      result.pins     = pins;
      result.done_res = finish.done;
      result.held     = held;
   end

   gpkd_out u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (result),
      .can_push  (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign rsp_select_n    = rsp_data.pins.select_n;
   assign rsp_clock_level = rsp_data.pins.clock_level;
   assign rsp_command_bit = rsp_data.pins.command_bit;
   assign rsp_done_res    = rsp_data.done_res;
   assign rsp_key_code    = rsp_data.held.key_code;
   assign rsp_id_byte     = rsp_data.held.id_byte;
   assign rsp_buttons     = rsp_data.held.buttons;
   assign rsp_right_x     = rsp_data.held.right_x;
   assign rsp_right_y     = rsp_data.held.right_y;
   assign rsp_left_x      = rsp_data.held.left_x;
   assign rsp_left_y      = rsp_data.held.left_y;

endmodule
